// ===== design/sjfst_pkg.sv =====
package sjfst_pkg;

  // default sizing
  localparam int MAX_PROCS_DEF  = 16;
  localparam int BURST_BITS_DEF = 16;

  // port field widths
  localparam int BURST_IN_W = 16;
  localparam int PID_W      = 5;
  localparam int BURST_O_W  = 16;
  localparam int WAIT_W     = 20;
  localparam int TAT_W      = 20;
  localparam int AVG_W      = 28;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 120;
  localparam int OUT_PAD_W  = OUT_DATA_W - (PID_W + BURST_O_W + WAIT_W + TAT_W + 2 * AVG_W);
  localparam int Q_FRAC     = 8;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_RD_I,
    ST_LD_I,
    ST_RD_J,
    ST_CMP,
    ST_WR_I,
    ST_SUM_RD,
    ST_SUM_ACC,
    ST_DIV,
    ST_EM_RD,
    ST_EM_OUT
  } sjf_state_t;

endpackage

// ===== design/sjf_schedule_timing_unit.sv =====
// Shortest-job-first schedule timing. Burst times stream in on the input channel, one beat per
// job, and are stored in a job memory with id = arrival position plus one; beats that arrive
// with the store full are dropped and set the overflow flag carried in out_tuser for that batch.
// The beat with in_tlast set closes the batch. The block then sorts the jobs with an exchange
// sort (position i against every later j, swap when burst i is strictly greater), sums the
// waiting times, divides both totals by the job count in Q.8 (truncated), and emits one result
// beat per job in schedule order with out_tlast on the final one. Loading accepts one beat per
// cycle while in_tready is high. After the closing beat the sort (two jobs or more) and the sums
// run, then two divisions of D = min(BURST_BITS, 16) + clog2(MAX_PROCS*(MAX_PROCS+1)/2+1) + 8
// quotient bits (32 at default sizing) on one shared restoring divider, one quotient bit a cycle;
// emission waits on any output stall. The job memory (one read and one write a cycle) sets the
// sort time. in_tready is low from the closing beat until the last result is loaded into the
// output register; the next batch may load while that final result still waits to be taken.
module sjf_schedule_timing_unit
  import sjfst_pkg::*;
#(
  parameter int MAX_PROCS  = MAX_PROCS_DEF,
  parameter int BURST_BITS = BURST_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [15:0] burst_in
  input  logic                  in_tlast,   // last_item
  // result channel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [4:0] process_id, [20:5] burst_out, [40:21] wait_time, [60:41] turnaround_time,
  // [88:61] avg_wait_q8, [116:89] avg_turnaround_q8, [119:117] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast,  // last_result
  output logic                  out_tuser   // overflow
);

  // stored burst width: only the low BURST_BITS of the 16 bit field are kept
  localparam int BW       = (BURST_BITS < BURST_IN_W) ? BURST_BITS : BURST_IN_W;
  localparam int CNT_W    = $clog2(MAX_PROCS + 1);
  localparam int AW       = $clog2(MAX_PROCS);
  localparam int IDW      = CNT_W;
  localparam int ENT_W    = IDW + BW;
  localparam int ACC_W    = BW + CNT_W;
  localparam int SUM_W    = BW + $clog2(MAX_PROCS * (MAX_PROCS + 1) / 2 + 1);
  localparam int DIV_W    = SUM_W + Q_FRAC;
  localparam int STEP_W   = $clog2(DIV_W);
  localparam int ID_EXT_W = (IDW > PID_W) ? IDW : PID_W;
  localparam int ACC_EXT_W = (ACC_W > WAIT_W) ? ACC_W : WAIT_W;
  localparam int Q_EXT_W  = (DIV_W > AVG_W) ? DIV_W : AVG_W;

  // job memory: {id, burst}, one write and one registered read a cycle
  logic [ENT_W-1:0] job_mem [MAX_PROCS];
  logic             mem_we;
  logic [AW-1:0]    mem_wa;
  logic [ENT_W-1:0] mem_wd;
  logic [AW-1:0]    rd_addr;
  logic [ENT_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      job_mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= job_mem[rd_addr];
  end

  // sequencer state
  sjf_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;       // jobs stored in this batch
  logic              ovf_r, ovf_nxt;       // beat dropped in this batch
  logic [AW-1:0]     i_r, i_nxt;           // sort outer position
  logic [AW-1:0]     j_r, j_nxt;           // sort inner position
  logic [AW-1:0]     k_r, k_nxt;           // sum / emission position
  logic [ENT_W-1:0]  cur_r, cur_nxt;       // running minimum held for position i
  logic [SUM_W-1:0]  wait_sum_r, wait_sum_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;       // running burst sum
  logic [DIV_W-1:0]  q_r, q_nxt;           // dividend shifting out, quotient shifting in
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              sel_r, sel_nxt;       // 0: wait average, 1: turnaround average
  logic [DIV_W-1:0]  avg_w_r, avg_w_nxt;
  logic [DIV_W-1:0]  avg_t_r, avg_t_nxt;

  // output register
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  out_last_r;
  logic                  out_user_r;
  logic                  load_out;
  logic                  load_last;

  // field views of the memory read
  logic [BW-1:0]  rd_burst;
  logic [IDW-1:0] rd_id;
  logic [BW-1:0]  cur_burst;
  logic [BW-1:0]  in_burst;

  assign rd_burst  = rd_data_r[BW-1:0];
  assign rd_id     = rd_data_r[ENT_W-1:BW];
  assign cur_burst = cur_r[BW-1:0];
  assign in_burst  = in_tdata[BW-1:0];

  // shared divider step: restoring, one quotient bit a cycle
  logic [CNT_W:0]   rem_sh;
  logic             div_ge;
  logic [CNT_W:0]   rem_sub;
  logic [DIV_W-1:0] q_shift;

  assign rem_sh  = {rem_r, q_r[DIV_W-1]};
  assign div_ge  = rem_sh >= {1'b0, cnt_r};
  assign rem_sub = div_ge ? (rem_sh - {1'b0, cnt_r}) : rem_sh;
  assign q_shift = {q_r[DIV_W-2:0], div_ge};

  // result fields of the job being emitted
  logic [ACC_W-1:0]     tat_val;
  logic [ID_EXT_W-1:0]  id_ext;
  logic [ACC_EXT_W-1:0] wait_ext;
  logic [ACC_EXT_W-1:0] tat_ext;
  logic [Q_EXT_W-1:0]   avg_w_ext;
  logic [Q_EXT_W-1:0]   avg_t_ext;
  logic [SUM_W-1:0]     tat_sum;
  logic [SUM_W-1:0]     wait_sum_add;

  assign tat_val      = acc_r + ACC_W'(rd_burst);
  assign id_ext       = ID_EXT_W'(rd_id);
  assign wait_ext     = ACC_EXT_W'(acc_r);
  assign tat_ext      = ACC_EXT_W'(tat_val);
  assign avg_w_ext    = Q_EXT_W'(avg_w_r);
  assign avg_t_ext    = Q_EXT_W'(avg_t_r);
  assign tat_sum      = wait_sum_r + SUM_W'(acc_r);
  assign wait_sum_add = wait_sum_r + SUM_W'(acc_r);

  assign in_tready  = (state_r == ST_LOAD);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    k_r        <= k_nxt;
    cur_r      <= cur_nxt;
    wait_sum_r <= wait_sum_nxt;
    acc_r      <= acc_nxt;
    q_r        <= q_nxt;
    rem_r      <= rem_nxt;
    step_r     <= step_nxt;
    sel_r      <= sel_nxt;
    avg_w_r    <= avg_w_nxt;
    avg_t_r    <= avg_t_nxt;
    if (load_out) begin
      out_data_r <= {{OUT_PAD_W{1'b0}}, avg_t_ext[AVG_W-1:0], avg_w_ext[AVG_W-1:0],
                     tat_ext[TAT_W-1:0], wait_ext[WAIT_W-1:0],
                     BURST_O_W'(rd_burst), id_ext[PID_W-1:0]};
      out_last_r <= load_last;
      out_user_r <= ovf_r;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    ovf_nxt      = ovf_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    k_nxt        = k_r;
    cur_nxt      = cur_r;
    wait_sum_nxt = wait_sum_r;
    acc_nxt      = acc_r;
    q_nxt        = q_r;
    rem_nxt      = rem_r;
    step_nxt     = step_r;
    sel_nxt      = sel_r;
    avg_w_nxt    = avg_w_r;
    avg_t_nxt    = avg_t_r;
    mem_we       = 1'b0;
    mem_wa       = cnt_r[AW-1:0];
    mem_wd       = {cnt_r + CNT_W'(1), in_burst};
    rd_addr      = k_r;
    load_out     = 1'b0;
    load_last    = 1'b0;

    unique case (state_r)
      ST_LOAD: begin
        if (in_tvalid) begin
          // store the job, or drop it when the memory is full
          if (cnt_r < CNT_W'(MAX_PROCS)) begin
            mem_we  = 1'b1;
            cnt_nxt = cnt_r + CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_tlast) begin
            i_nxt        = '0;
            k_nxt        = '0;
            acc_nxt      = '0;
            wait_sum_nxt = '0;
            state_nxt    = (cnt_nxt >= CNT_W'(2)) ? ST_RD_I : ST_SUM_RD;
          end
        end
      end

      ST_RD_I: begin
        rd_addr   = i_r;
        j_nxt     = i_r + AW'(1);
        state_nxt = ST_LD_I;
      end

      ST_LD_I: begin
        // entry i arrives while entry i+1 is read
        rd_addr   = j_r;
        cur_nxt   = rd_data_r;
        state_nxt = ST_CMP;
      end

      ST_RD_J: begin
        rd_addr   = j_r;
        state_nxt = ST_CMP;
      end

      ST_CMP: begin
        rd_addr = j_r;
        if (cur_burst > rd_burst) begin
          // swap: larger job moves to j, smaller stays held for i
          mem_we  = 1'b1;
          mem_wa  = j_r;
          mem_wd  = cur_r;
          cur_nxt = rd_data_r;
        end
        if (CNT_W'(j_r) + CNT_W'(1) == cnt_r) begin
          state_nxt = ST_WR_I;
        end else begin
          j_nxt     = j_r + AW'(1);
          state_nxt = ST_RD_J;
        end
      end

      ST_WR_I: begin
        mem_we = 1'b1;
        mem_wa = i_r;
        mem_wd = cur_r;
        if (CNT_W'(i_r) + CNT_W'(2) == cnt_r) begin
          k_nxt     = '0;
          state_nxt = ST_SUM_RD;
        end else begin
          i_nxt     = i_r + AW'(1);
          state_nxt = ST_RD_I;
        end
      end

      ST_SUM_RD: begin
        state_nxt = ST_SUM_ACC;
      end

      ST_SUM_ACC: begin
        wait_sum_nxt = wait_sum_add;
        acc_nxt      = acc_r + ACC_W'(rd_burst);
        if (CNT_W'(k_r) + CNT_W'(1) == cnt_r) begin
          q_nxt     = {wait_sum_add, {Q_FRAC{1'b0}}};
          rem_nxt   = '0;
          step_nxt  = '0;
          sel_nxt   = 1'b0;
          state_nxt = ST_DIV;
        end else begin
          k_nxt     = k_r + AW'(1);
          state_nxt = ST_SUM_RD;
        end
      end

      ST_DIV: begin
        q_nxt    = q_shift;
        rem_nxt  = rem_sub[CNT_W-1:0];
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(DIV_W - 1)) begin
          if (!sel_r) begin
            avg_w_nxt = q_shift;
            // turnaround total = wait total + total burst
            q_nxt     = {tat_sum, {Q_FRAC{1'b0}}};
            rem_nxt   = '0;
            step_nxt  = '0;
            sel_nxt   = 1'b1;
          end else begin
            avg_t_nxt = q_shift;
            acc_nxt   = '0;
            k_nxt     = '0;
            state_nxt = ST_EM_RD;
          end
        end
      end

      ST_EM_RD: begin
        state_nxt = ST_EM_OUT;
      end

      ST_EM_OUT: begin
        // hold the read address so the entry stays on rd_data_r during a stall
        if (!out_valid_r || out_tready) begin
          load_out = 1'b1;
          acc_nxt  = tat_val;
          if (CNT_W'(k_r) + CNT_W'(1) == cnt_r) begin
            load_last = 1'b1;
            cnt_nxt   = '0;
            ovf_nxt   = 1'b0;
            state_nxt = ST_LOAD;
          end else begin
            k_nxt     = k_r + AW'(1);
            state_nxt = ST_EM_RD;
          end
        end
      end

      default: begin
        state_nxt = ST_LOAD;
      end
    endcase

    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

endmodule
